// ===== rtl/ibt_pkg.sv =====
// ----------------------------------------------------------------------------
// ibt_pkg: shared types for the timed IPv4 ban table
// Request and response payloads, the per-cell broadcast request, the
// neighbor-to-neighbor chain signals and the control states.
// ----------------------------------------------------------------------------
package ibt_pkg;

  // Slot count of the table (one cell per slot)
  localparam int unsigned TableEntries = 16;

  localparam logic [31:0] ExpiryMax = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT
  } ctl_state_e;

  // Incoming request payload
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] ip_address;
    logic        is_wildcard;
    logic [31:0] duration_ms;
    logic [31:0] now_ms;
  } in_req_t;

  // Result payload
  typedef struct packed {
    logic hit;
    logic status;
  } out_rsp_t;

  // Request as broadcast to every cell
  typedef struct packed {
    mode_e       mode;
    logic [31:0] addr;      // zero for a wildcard key
    logic        wild;
    logic [31:0] now_ms;
    logic [31:0] expiry;    // saturated now + duration, zero = permanent
  } cell_req_t;

  // Flags handed from one cell to the next (OR of everything upstream)
  typedef struct packed {
    logic found;   // a live entry with an equal key
    logic free;    // a slot that is not live
    logic hit;     // a lookup match
  } chain_t;

endpackage

// ===== rtl/timed_ip_ban_table.sv =====
// ----------------------------------------------------------------------------
// timed_ip_ban_table: IPv4 ban table with per-entry expiry
// A row of slot cells with lowest-index priority carried cell to cell.
// Add refreshes or inserts, remove deletes, lookup checks, clear empties.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | in_valid_i / in_ready_o   | in_req_i  (ibt_pkg::in_req_t)
//  out     | output    | out_valid_o / out_ready_i | out_rsp_o (ibt_pkg::out_rsp_t)
//
//  Steps: the accepting edge captures the request, ST_EVAL evaluates in every
//    cell, ST_COMMIT commits through the cell chain; in_ready_o is high only in
//    ST_IDLE, so a new request is taken only after the last one has committed.
//  What each cell commits is set by the priority chain that runs through all cells.
//  Reset empties the table at once; no clearing pass.
//  A result waiting on out_ready_i does not block the next request's
//  acceptance and evaluation; only its commit waits for the output register.
// ----------------------------------------------------------------------------
module timed_ip_ban_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ibt_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ibt_pkg::out_rsp_t out_rsp_o
);

  localparam int unsigned N = ibt_pkg::TableEntries;

  ibt_pkg::ctl_state_e state_q, state_d;
  ibt_pkg::in_req_t    req_q;
  ibt_pkg::cell_req_t  cell_req;
  ibt_pkg::out_rsp_t   rsp_q, rsp_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;
  logic                eval;
  logic                commit;
  logic [32:0]         exp_sum;

  ibt_pkg::chain_t     chain_s [N+1];
  logic [N-1:0]        valid_vec;
  logic                found_all;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ibt_pkg::ST_IDLE);

  // captured request; stays put until the commit
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
  end

  // saturating expiry: now + duration, zero duration means permanent
  assign exp_sum = {1'b0, req_q.now_ms} + {1'b0, req_q.duration_ms};

  always_comb begin
    cell_req.mode   = ibt_pkg::mode_e'(req_q.mode);
    cell_req.wild   = req_q.is_wildcard;
    cell_req.addr   = req_q.is_wildcard ? '0 : req_q.ip_address;
    cell_req.now_ms = req_q.now_ms;
    if (req_q.duration_ms == '0) begin
      cell_req.expiry = '0;
    end else if (exp_sum[32]) begin
      cell_req.expiry = ibt_pkg::ExpiryMax;
    end else begin
      cell_req.expiry = exp_sum[31:0];
    end
  end

  // cell row, slot 0 has top priority
  assign chain_s[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    ibt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .req_i       (cell_req),
      .eval_i      (eval),
      .commit_i    (commit),
      .chain_i     (chain_s[i]),
      .found_all_i (found_all),
      .chain_o     (chain_s[i+1]),
      .valid_o     (valid_vec[i])
    );
  end

  assign found_all = chain_s[N].found;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ibt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  always_comb begin
    state_d     = state_q;
    eval        = 1'b0;
    commit      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    rsp_d       = rsp_q;
    unique case (state_q)
      ibt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = ibt_pkg::ST_EVAL;
        end
      end
      ibt_pkg::ST_EVAL: begin
        eval    = 1'b1;
        state_d = ibt_pkg::ST_COMMIT;
      end
      ibt_pkg::ST_COMMIT: begin
        // hold the commit until the output register is free
        if (!out_valid_q || out_ready_i) begin
          commit       = 1'b1;
          out_valid_d  = 1'b1;
          rsp_d.hit    = (cell_req.mode == ibt_pkg::MODE_LOOKUP) && chain_s[N].hit;
          rsp_d.status = (cell_req.mode == ibt_pkg::MODE_ADD) && !found_all &&
                         !chain_s[N].free;
          state_d      = ibt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ibt_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // checks
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ibt_pkg::ST_EVAL))
    else $error("accepted request did not move to evaluation");

  a_eval_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ibt_pkg::ST_EVAL) |=> (state_q == ibt_pkg::ST_COMMIT))
    else $error("evaluation not followed by commit state");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (cell_req.mode == ibt_pkg::MODE_CLEAR)) |=> (valid_vec == '0))
    else $error("table not empty after clear");

  a_add_stores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (cell_req.mode == ibt_pkg::MODE_ADD) && !rsp_d.status) |=> (|valid_vec))
    else $error("successful add left table empty");

  a_hit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.hit && out_rsp_o.status))
    else $error("hit and full reported together");

endmodule

// ===== rtl/ibt_cell.sv =====
// ----------------------------------------------------------------------------
// ibt_cell: one slot of the ban table
// Holds one key and expiry. Evaluates the broadcast request, then takes the
// upstream chain flags, adds its own and hands them to the next cell.
// ----------------------------------------------------------------------------
module ibt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ibt_pkg::cell_req_t req_i,
  input  logic              eval_i,
  input  logic              commit_i,
  input  ibt_pkg::chain_t   chain_i,
  input  logic              found_all_i,
  output ibt_pkg::chain_t   chain_o,
  output logic              valid_o
);

  logic        valid_q;
  logic [31:0] addr_q;
  logic        wild_q;
  logic [31:0] expiry_q;

  logic        live_q;
  logic        eq_q;
  logic        live;
  logic        eq;

  assign live = valid_q && ((expiry_q == '0) || (expiry_q >= req_i.now_ms));
  assign eq   = (wild_q || req_i.wild) ? (wild_q && req_i.wild)
                                       : (addr_q == req_i.addr);

  // evaluation flags, sampled in ST_EVAL and held for the commit
  always_ff @(posedge clk_i) begin
    if (eval_i) begin
      live_q <= live;
      eq_q   <= eq;
    end
  end

  assign chain_o.found = chain_i.found || (live_q && eq_q);
  assign chain_o.free  = chain_i.free || !live_q;
  assign chain_o.hit   = chain_i.hit || (live_q && (wild_q || eq_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (commit_i) begin
      case (req_i.mode)
        ibt_pkg::MODE_ADD: begin
          if (!found_all_i && !live_q && !chain_i.free) begin
            valid_q <= 1'b1;
          end
        end
        ibt_pkg::MODE_REMOVE: begin
          if (valid_q && eq_q) begin
            valid_q <= 1'b0;
          end
        end
        ibt_pkg::MODE_CLEAR: begin
          valid_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // key and expiry, written only by an add
  always_ff @(posedge clk_i) begin
    if (commit_i && (req_i.mode == ibt_pkg::MODE_ADD)) begin
      if (live_q && eq_q && !chain_i.found) begin
        expiry_q <= req_i.expiry;
      end else if (!found_all_i && !live_q && !chain_i.free) begin
        addr_q   <= req_i.addr;
        wild_q   <= req_i.wild;
        expiry_q <= req_i.expiry;
      end
    end
  end

  assign valid_o = valid_q;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the timed IPv4 ban table
// Directed requests cover the extreme field values, expiry, time running
// backwards, wildcard keys and a full table. Long random traffic follows,
// under three back-pressure profiles. An in-bench model predicts every result.
// ----------------------------------------------------------------------------
module tb_top;
  import ibt_pkg::*;

  localparam int unsigned PoolSize = 24;  // more keys than slots, so the table fills

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_req_t   in_req_i;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_rsp_t  out_rsp_o;

  // Percent of cycles in which each side holds off
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int unsigned mismatch_count = 0;
  int unsigned rsp_count      = 0;

  // Shadow copy of the ban table
  logic        ban_valid  [TableEntries];
  logic [31:0] ban_addr   [TableEntries];
  logic        ban_wild   [TableEntries];
  logic [31:0] ban_expiry [TableEntries];

  // Results predicted for accepted requests, oldest first
  out_rsp_t    pending_rsp_q [$];
  out_rsp_t    oldest_rsp;

  timed_ip_ban_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop: well past the slowest legal run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Model of the table
  // ---------------------------------------------------------------------------

  // Entry counts only while unexpired; expiry zero never runs out
  function automatic logic slot_is_live(int unsigned s, logic [31:0] now);
    return ban_valid[s] && (ban_expiry[s] == 32'd0 || ban_expiry[s] >= now);
  endfunction

  // Wildcard keys match each other only; address keys match by value
  function automatic logic slot_key_match(int unsigned s, logic [31:0] addr, logic wild);
    if (ban_wild[s] || wild) return ban_wild[s] && wild;
    return ban_addr[s] == addr;
  endfunction

  // Works out the result of one request and applies it to the shadow table
  function automatic out_rsp_t predict_ban_response(in_req_t req);
    out_rsp_t    rsp;
    logic [31:0] addr;
    logic [32:0] sum;
    logic [31:0] expiry;
    int          found;
    int          free_slot;
    rsp       = '0;
    addr      = req.is_wildcard ? 32'd0 : req.ip_address;
    found     = -1;
    free_slot = -1;
    case (mode_e'(req.mode))
      MODE_ADD: begin
        sum    = {1'b0, req.now_ms} + {1'b0, req.duration_ms};
        expiry = (req.duration_ms == 32'd0) ? 32'd0 : (sum[32] ? ExpiryMax : sum[31:0]);
        // lowest live duplicate wins; otherwise lowest dead slot
        for (int unsigned s = 0; s < TableEntries; s++) begin
          if (slot_is_live(s, req.now_ms)) begin
            if (found < 0 && slot_key_match(s, addr, req.is_wildcard)) found = s;
          end else if (free_slot < 0) begin
            free_slot = s;
          end
        end
        if (found >= 0) begin
          ban_expiry[found] = expiry;
        end else if (free_slot >= 0) begin
          ban_valid[free_slot]  = 1'b1;
          ban_addr[free_slot]   = addr;
          ban_wild[free_slot]   = req.is_wildcard;
          ban_expiry[free_slot] = expiry;
        end else begin
          rsp.status = 1'b1;
        end
      end
      MODE_REMOVE: begin
        // expired entries go too
        for (int unsigned s = 0; s < TableEntries; s++)
          if (ban_valid[s] && slot_key_match(s, addr, req.is_wildcard)) ban_valid[s] = 1'b0;
      end
      MODE_LOOKUP: begin
        for (int unsigned s = 0; s < TableEntries; s++)
          if (slot_is_live(s, req.now_ms) &&
              (ban_wild[s] || slot_key_match(s, addr, req.is_wildcard)))
            rsp.hit = 1'b1;
      end
      default: begin
        for (int unsigned s = 0; s < TableEntries; s++) ban_valid[s] = 1'b0;
      end
    endcase
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH result %0d: %s", $time, rsp_count, msg);
  endtask

  function automatic in_req_t make_req(mode_e mode, logic [31:0] ip, logic wild,
                                       logic [31:0] dur, logic [31:0] now);
    in_req_t req;
    req.mode        = mode;
    req.ip_address  = ip;
    req.is_wildcard = wild;
    req.duration_ms = dur;
    req.now_ms      = now;
    return req;
  endfunction

  // One request: random hold-off, then hold valid until accepted.
  // Valid is left high so a back-to-back request keeps it up.
  task automatic send_request(in_req_t req);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    pending_rsp_q = {pending_rsp_q, predict_ban_response(req)};
  endtask

  // Sender goes quiet until every result is back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        oldest_rsp = pending_rsp_q.pop_front();
        if (out_rsp_o.hit !== oldest_rsp.hit)
          report_mismatch($sformatf("hit %b, want %b", out_rsp_o.hit, oldest_rsp.hit));
        if (out_rsp_o.status !== oldest_rsp.status)
          report_mismatch($sformatf("status %b, want %b",
                                    out_rsp_o.status, oldest_rsp.status));
      end
      rsp_count++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // All-ones / all-zero addresses and times; expiry sum saturating at the top
  task automatic test_field_extremes();
    send_request(make_req(MODE_ADD,    32'hFFFF_FFFF, 1'b0, 32'd0,         32'd0));
    send_request(make_req(MODE_LOOKUP, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_req(MODE_ADD,    32'd0,         1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_req(MODE_LOOKUP, 32'd0,         1'b0, 32'd0,         32'hFFFF_FFFF));
  endtask

  // Expiry edge, time going backwards, refresh of a live duplicate
  task automatic test_expiry();
    send_request(make_req(MODE_ADD,    32'h0102_0304, 1'b0, 32'd10, 32'd100));
    send_request(make_req(MODE_LOOKUP, 32'h0102_0304, 1'b0, 32'd0,  32'd111));
    send_request(make_req(MODE_LOOKUP, 32'h0102_0304, 1'b0, 32'd0,  32'd50));
    send_request(make_req(MODE_ADD,    32'h0102_0304, 1'b0, 32'd5,  32'd100));
  endtask

  // Star key: address ignored, matches every lookup, removed by another star
  task automatic test_wildcard();
    send_request(make_req(MODE_ADD,    32'hDEAD_BEEF, 1'b1, 32'd0, 32'd200));
    send_request(make_req(MODE_LOOKUP, 32'h0A0B_0C0D, 1'b0, 32'd0, 32'd200));
    send_request(make_req(MODE_REMOVE, 32'h1234_5678, 1'b1, 32'd0, 32'd200));
    send_request(make_req(MODE_LOOKUP, 32'h0A0B_0C0D, 1'b1, 32'd0, 32'd200));
  endtask

  // Fill all slots, drop an add, refresh in a full table, reuse an expired slot
  task automatic test_table_full();
    // two live entries remain; the 0x01020304 slot has expired by now 300
    for (int unsigned i = 0; i < TableEntries - 2; i++)
      send_request(make_req(MODE_ADD, 32'hC0A8_0000 + i, 1'b0,
                            (i == 0) ? 32'd10 : 32'd0, 32'd300));
    send_request(make_req(MODE_ADD,   32'hC0A8_00FF, 1'b0, 32'd0, 32'd300));
    send_request(make_req(MODE_ADD,   32'hC0A8_0001, 1'b0, 32'd0, 32'd305));
    send_request(make_req(MODE_ADD,   32'hC0A8_00FF, 1'b0, 32'd0, 32'd400));
    send_request(make_req(MODE_CLEAR, 32'h5A5A_A5A5, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  // Mostly adds/lookups/removes over a small key pool with a slowly moving
  // clock, plus random addresses, big durations and time jumps as noise.
  task automatic test_random_traffic();
    logic [31:0] addr_pool [PoolSize];
    logic [31:0] clock_ms;
    int unsigned pick;
    int unsigned per_phase;
    in_req_t     req;
    per_phase = 534;
    clock_ms  = 32'd1000;
    for (int unsigned k = 0; k < PoolSize; k++) addr_pool[k] = $urandom();
    for (int unsigned phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 76 : 0;
      recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 29 : 0;
      for (int unsigned n = 0; n < per_phase; n++) begin
        // hold-off mid-phase: let the table settle with nothing in flight
        if (n == per_phase / 2) drain_results();
        pick = $urandom_range(99);
        if (pick < 90)      clock_ms = clock_ms + $urandom_range(20);
        else if (pick < 94) clock_ms = (clock_ms > 200) ? clock_ms - $urandom_range(200) : 0;
        else if (pick < 97) clock_ms = $urandom();
        else                clock_ms = 32'hFFFF_FFFF - $urandom_range(100);
        req.now_ms = clock_ms;

        pick = $urandom_range(99);
        req.mode = (pick < 42) ? MODE_ADD : (pick < 78) ? MODE_LOOKUP :
                   (pick < 98) ? MODE_REMOVE : MODE_CLEAR;
        req.is_wildcard = ($urandom_range(99) < 8);
        req.ip_address  = ($urandom_range(99) < 85) ?
                          addr_pool[$urandom_range(PoolSize - 1)] : $urandom();

        pick = $urandom_range(99);
        if (pick < 30)      req.duration_ms = 32'd0;
        else if (pick < 80) req.duration_ms = $urandom_range(60, 1);
        else if (pick < 90) req.duration_ms = $urandom();
        else                req.duration_ms = 32'hFFFF_FFFF - $urandom_range(50);
        send_request(req);
      end
      drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    for (int unsigned s = 0; s < TableEntries; s++) begin
      ban_valid[s]  = 1'b0;
      ban_addr[s]   = '0;
      ban_wild[s]   = 1'b0;
      ban_expiry[s] = '0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 29;
    recv_idle_pct = 76;
    test_field_extremes();
    test_expiry();
    test_wildcard();
    test_table_full();
    drain_results();
    test_random_traffic();

    // all results back; keep the clock running to catch any stray result
    drain_results();
    repeat (10) @(posedge clk_i);
    if (pending_rsp_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_rsp_q.size()));
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
